// ===== rtl/clea_pkg.sv =====
// Shared types and constants for the circular log entry allocator.
package clea_pkg;

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int PSIZE_W   = 16;
    localparam int STRIDE_W  = 16;
    localparam int BYTES_W   = 17;
    localparam int UNITS_W   = 13;
    localparam int FREE_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W  = 2;

    localparam int NEAR_FULL_BYTES = 128;

    // Commands
    localparam logic [CMD_W-1:0] CMD_SIZED     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STRIDE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESET_NF  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RST_DONE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RST_SKIP = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_END   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC_MODE    = 2'd2;

    localparam logic [CFG_W-1:0] BUFFER_END_RST = 32'd65536;

    // Status group that travels with every result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wrapped;
        logic                empty;
        logic                full;
    } t_stat;

endpackage

// ===== rtl/clea_calc.sv =====
// Single-pass allocation datapath: request sizing, fit check, wrap retry, status.
module clea_calc #(
    parameter int HEADER_BYTES = 32,
    parameter int ALLOC_UNIT   = 16,
    parameter int LOG_START    = 256,
    parameter int ADDR_WIDTH   = 32
) (
    input  logic [clea_pkg::CMD_W-1:0]    i_command,
    input  logic [clea_pkg::PSIZE_W-1:0]  i_payload_size,
    input  logic [clea_pkg::CFG_W-1:0]    i_buffer_end,
    input  logic [clea_pkg::STRIDE_W-1:0] i_entry_stride,
    input  logic                          i_circular_mode,
    input  logic [ADDR_WIDTH:0]           i_next_free,
    input  logic                          i_wrapped,
    output logic [ADDR_WIDTH:0]           o_next_free,
    output logic                          o_wrapped,
    output clea_pkg::t_stat               o_stat,
    output logic [ADDR_WIDTH-1:0]         o_entry_address,
    output logic [ADDR_WIDTH-1:0]         o_payload_address,
    output logic [clea_pkg::BYTES_W-1:0]  o_total_bytes,
    output logic [clea_pkg::BYTES_W-1:0]  o_payload_bytes,
    output logic [clea_pkg::UNITS_W-1:0]  o_length_units,
    output logic [clea_pkg::FREE_W-1:0]   o_free_bytes
);

    localparam int NW      = ADDR_WIDTH + 1;
    localparam int EW      = (NW > clea_pkg::CFG_W) ? NW : clea_pkg::CFG_W;
    localparam int CW      = EW + 2;
    localparam int UNIT_LG = $clog2(ALLOC_UNIT);
    localparam int BW      = clea_pkg::BYTES_W;

    localparam logic [BW-1:0] UNIT_MASK = BW'(ALLOC_UNIT - 1);
    localparam logic [CW-1:0] NF_MAX    = CW'((CW'(1) << NW) - CW'(1));

    function automatic logic [NW-1:0] sat_nf(input logic [CW-1:0] s);
        return (s > NF_MAX) ? NF_MAX[NW-1:0] : s[NW-1:0];
    endfunction

    logic [BW-1:0] w_sized_sum, w_stride_sum, w_req, w_req_shift;
    logic [CW-1:0] w_be, w_nf, w_req_x, w_sum0, w_sum1, w_nf_new_x;
    logic          w_ok0, w_ok1, w_ok, w_retry, w_near;
    logic [NW-1:0] w_start, w_nf_new;
    logic          w_alloc, w_granted;
    logic [clea_pkg::STATUS_W-1:0] w_status;

    // unit is a power of two: round up is add-and-mask
    assign w_sized_sum  = BW'(i_payload_size) + BW'(HEADER_BYTES) + UNIT_MASK;
    assign w_stride_sum = BW'(i_entry_stride) + UNIT_MASK;
    assign w_req        = (i_command == clea_pkg::CMD_SIZED) ? (w_sized_sum & ~UNIT_MASK)
                                                             : (w_stride_sum & ~UNIT_MASK);

    assign w_be    = CW'(i_buffer_end);
    assign w_nf    = CW'(i_next_free);
    assign w_req_x = CW'(w_req);

    assign w_sum0  = w_nf + w_req_x;
    assign w_ok0   = (w_sum0 <= w_be);
    assign w_sum1  = CW'(LOG_START) + w_req_x;
    assign w_ok1   = (w_sum1 <= w_be);
    assign w_retry = !w_ok0 && i_circular_mode;
    assign w_ok    = w_retry ? w_ok1 : w_ok0;
    assign w_start = w_retry ? NW'(LOG_START) : i_next_free;
    assign w_near  = (w_nf + CW'(clea_pkg::NEAR_FULL_BYTES)) >= w_be;

    assign w_alloc   = (i_command == clea_pkg::CMD_SIZED) || (i_command == clea_pkg::CMD_STRIDE);
    assign w_granted = w_alloc && w_ok;

    always_comb begin
        w_nf_new  = i_next_free;
        o_wrapped = i_wrapped;
        w_status  = clea_pkg::ST_RST_SKIP;
        case (i_command)
            clea_pkg::CMD_SIZED, clea_pkg::CMD_STRIDE: begin
                w_nf_new = w_retry ? sat_nf(w_sum1) : sat_nf(w_sum0);
                if (w_retry) begin
                    o_wrapped = 1'b1;
                end
                w_status = w_ok ? clea_pkg::ST_GRANTED : clea_pkg::ST_REFUSED;
            end
            clea_pkg::CMD_RESET: begin
                w_nf_new  = NW'(LOG_START);
                o_wrapped = 1'b0;
                w_status  = clea_pkg::ST_RST_DONE;
            end
            default: begin
                if (w_near) begin
                    w_nf_new  = NW'(LOG_START);
                    o_wrapped = 1'b0;
                    w_status  = clea_pkg::ST_RST_DONE;
                end
            end
        endcase
    end

    assign o_next_free  = w_nf_new;
    assign w_nf_new_x   = CW'(w_nf_new);
    assign o_stat       = '{status:  w_status,
                            wrapped: o_wrapped,
                            empty:   (w_nf_new == NW'(LOG_START)),
                            full:    (w_nf_new_x >= w_be)};
    assign o_free_bytes = (w_nf_new_x < w_be) ? clea_pkg::FREE_W'(w_be - w_nf_new_x)
                                              : '0;

    assign w_req_shift = w_req >> UNIT_LG;

    assign o_entry_address   = w_granted ? w_start[ADDR_WIDTH-1:0] : '0;
    assign o_payload_address = w_granted ? (w_start[ADDR_WIDTH-1:0] + ADDR_WIDTH'(HEADER_BYTES))
                                         : '0;
    assign o_total_bytes     = w_granted ? w_req : '0;
    assign o_payload_bytes   = (w_granted && (w_req > BW'(HEADER_BYTES)))
                             ? (w_req - BW'(HEADER_BYTES)) : '0;
    assign o_length_units    = w_granted ? w_req_shift[clea_pkg::UNITS_W-1:0] : '0;

endmodule

// ===== rtl/clea_out_buf.sv =====
// Result register with a skid stage; upstream stall is registered.
module clea_out_buf #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DATA_W-1:0] i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_out_data
);

    logic              r_main_valid, r_skid_valid;
    logic [DATA_W-1:0] r_main, r_skid;
    logic              w_take, w_push;

    assign o_in_stall  = r_skid_valid;
    assign w_push      = i_in_valid && !r_skid_valid;
    assign w_take      = r_main_valid && !i_out_stall;
    assign o_out_valid = r_main_valid;
    assign o_out_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_push && r_main_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else if (!r_main_valid || w_take) begin
                r_main_valid <= w_push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_main <= r_skid;
            end
        end else if (w_push) begin
            if (r_main_valid && !w_take) begin
                r_skid <= i_in_data;
            end else begin
                r_main <= i_in_data;
            end
        end
    end

endmodule

// ===== rtl/circular_log_entry_allocator_unit.sv =====
// Top level of the circular log entry allocator.
//
// Bump allocator for a trace/log buffer. Input channel (i_valid/o_stall)
// takes one request word: command and payload size. Output channel
// (o_valid/i_stall) returns one result word per request: status, entry and
// payload addresses, sizes, length in allocation units and buffer flags.
// A word moves at a clock edge where valid is high and stall is low.
//
// A result is registered: it is written to the result register at the edge its
// request is taken, or to the skid stage while the result register is held.
// Throughput: one request per cycle while o_stall is low. The allocation is a
// single add, compare and wrap select against the live pointer, so the pointer is updated
// at the same edge the request is taken and the next request sees it. The result register
// has a one-word skid stage; o_stall rises only when both are full, i.e. after a stall.
//
// Reset (i_rst_n low, synchronous): pointer to LOG_START, wrapped cleared,
// result/skid empty, registers to buffer_end 65536, stride 0, linear mode.
// Config writes (i_cfg_we/i_cfg_index/i_cfg_wdata) take effect next cycle
// and are expected only while the block is idle.
// ALLOC_UNIT must be a power of two.
module circular_log_entry_allocator_unit #(
    parameter int HEADER_BYTES = 32,
    parameter int ALLOC_UNIT   = 16,
    parameter int LOG_START    = 256,
    parameter int ADDR_WIDTH   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [clea_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [clea_pkg::CFG_W-1:0]       i_cfg_wdata,
    // request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [clea_pkg::CMD_W-1:0]       i_command,
    input  logic [clea_pkg::PSIZE_W-1:0]     i_payload_size,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [clea_pkg::STATUS_W-1:0]    o_status,
    output logic [ADDR_WIDTH-1:0]            o_entry_address,
    output logic [ADDR_WIDTH-1:0]            o_payload_address,
    output logic [clea_pkg::BYTES_W-1:0]     o_total_bytes,
    output logic [clea_pkg::BYTES_W-1:0]     o_payload_bytes,
    output logic [clea_pkg::UNITS_W-1:0]     o_length_units,
    output logic                             o_wrapped_flag,
    output logic                             o_empty_flag,
    output logic                             o_full_flag,
    output logic [clea_pkg::FREE_W-1:0]      o_free_bytes
);

    localparam int NW     = ADDR_WIDTH + 1;
    localparam int STAT_W = $bits(clea_pkg::t_stat);
    localparam int DATA_W = STAT_W + 2 * ADDR_WIDTH + 2 * clea_pkg::BYTES_W
                          + clea_pkg::UNITS_W + clea_pkg::FREE_W;

    // configuration registers
    logic [clea_pkg::CFG_W-1:0]    r_buffer_end;
    logic [clea_pkg::STRIDE_W-1:0] r_entry_stride;
    logic                          r_circular_mode;

    // allocator state
    logic [NW-1:0] r_next_free, n_next_free;
    logic          r_wrapped, n_wrapped;

    logic                          w_accept;
    clea_pkg::t_stat               w_stat, w_out_stat;
    logic [ADDR_WIDTH-1:0]         w_entry, w_paddr;
    logic [clea_pkg::BYTES_W-1:0]  w_total, w_pbytes;
    logic [clea_pkg::UNITS_W-1:0]  w_units;
    logic [clea_pkg::FREE_W-1:0]   w_free;
    logic [DATA_W-1:0]             w_in_data, w_out_data;

    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_end    <= clea_pkg::BUFFER_END_RST;
            r_entry_stride  <= '0;
            r_circular_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clea_pkg::CFG_BUFFER_END:   r_buffer_end    <= i_cfg_wdata;
                clea_pkg::CFG_ENTRY_STRIDE: r_entry_stride  <= i_cfg_wdata[clea_pkg::STRIDE_W-1:0];
                clea_pkg::CFG_CIRC_MODE:    r_circular_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    clea_calc #(
        .HEADER_BYTES (HEADER_BYTES),
        .ALLOC_UNIT   (ALLOC_UNIT),
        .LOG_START    (LOG_START),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_calc (
        .i_command         (i_command),
        .i_payload_size    (i_payload_size),
        .i_buffer_end      (r_buffer_end),
        .i_entry_stride    (r_entry_stride),
        .i_circular_mode   (r_circular_mode),
        .i_next_free       (r_next_free),
        .i_wrapped         (r_wrapped),
        .o_next_free       (n_next_free),
        .o_wrapped         (n_wrapped),
        .o_stat            (w_stat),
        .o_entry_address   (w_entry),
        .o_payload_address (w_paddr),
        .o_total_bytes     (w_total),
        .o_payload_bytes   (w_pbytes),
        .o_length_units    (w_units),
        .o_free_bytes      (w_free)
    );

    // pointer and wrapped bit move only when a request word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= NW'(LOG_START);
            r_wrapped   <= 1'b0;
        end else if (w_accept) begin
            r_next_free <= n_next_free;
            r_wrapped   <= n_wrapped;
        end
    end

    assign w_in_data = {w_stat, w_entry, w_paddr, w_total, w_pbytes, w_units, w_free};

    clea_out_buf #(
        .DATA_W (DATA_W)
    ) u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .i_in_data   (w_in_data),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_out_data  (w_out_data)
    );

    assign {w_out_stat, o_entry_address, o_payload_address, o_total_bytes,
            o_payload_bytes, o_length_units, o_free_bytes} = w_out_data;

    assign o_status       = w_out_stat.status;
    assign o_wrapped_flag = w_out_stat.wrapped;
    assign o_empty_flag   = w_out_stat.empty;
    assign o_full_flag    = w_out_stat.full;

    // non-granted results carry no entry
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != clea_pkg::ST_GRANTED))
        |-> (o_entry_address == '0 && o_total_bytes == '0 && o_length_units == '0))
        else $error("non-granted result carries entry fields");

    // payload follows the header inside a granted entry
    a_paddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == clea_pkg::ST_GRANTED))
        |-> (o_payload_address == o_entry_address + ADDR_WIDTH'(HEADER_BYTES)))
        else $error("payload address not entry plus header");

    // wrapped can only be set by a taken request in circular mode
    a_wrap_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_wrapped) |-> $past(w_accept && r_circular_mode))
        else $error("wrapped set without a circular allocation");

    // a performed reset leaves the buffer empty and unwrapped
    a_rst_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == clea_pkg::ST_RST_DONE))
        |-> (o_empty_flag && !o_wrapped_flag))
        else $error("reset result not empty");

endmodule

// ===== test/tb_circular_log_entry_allocator_unit.sv =====
// Self-checking testbench for the circular log entry allocator.
`timescale 1ns / 100ps

module tb_circular_log_entry_allocator_unit;

    localparam int HEADER_BYTES = 32;
    localparam int ALLOC_UNIT   = 16;
    localparam int LOG_START    = 256;
    localparam int ADDR_WIDTH   = 32;

    // Pointer saturates at the top of its 33-bit range
    localparam longint unsigned PTR_MAX = (64'd1 << (ADDR_WIDTH + 1)) - 64'd1;

    // Cycles without any word moving on either channel before giving up
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // One request word as driven on the input channel
    typedef struct {
        logic [clea_pkg::CMD_W-1:0]   cmd;
        logic [clea_pkg::PSIZE_W-1:0] psize;
    } t_log_request;

    // One result word, at the widths of the output ports
    typedef struct {
        logic [clea_pkg::STATUS_W-1:0] status;
        logic [ADDR_WIDTH-1:0]         entry_address;
        logic [ADDR_WIDTH-1:0]         payload_address;
        logic [clea_pkg::BYTES_W-1:0]  total_bytes;
        logic [clea_pkg::BYTES_W-1:0]  payload_bytes;
        logic [clea_pkg::UNITS_W-1:0]  length_units;
        logic                          wrapped;
        logic                          empty;
        logic                          full;
        logic [clea_pkg::FREE_W-1:0]   free_bytes;
    } t_alloc_result;

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_we       = 1'b0;
    logic [clea_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [clea_pkg::CFG_W-1:0]     i_cfg_wdata    = '0;
    logic                           i_valid        = 1'b0;
    logic [clea_pkg::CMD_W-1:0]     i_command      = '0;
    logic [clea_pkg::PSIZE_W-1:0]   i_payload_size = '0;
    logic                           i_stall        = 1'b0;

    logic                          o_stall;
    logic                          o_valid;
    logic [clea_pkg::STATUS_W-1:0] o_status;
    logic [ADDR_WIDTH-1:0]         o_entry_address;
    logic [ADDR_WIDTH-1:0]         o_payload_address;
    logic [clea_pkg::BYTES_W-1:0]  o_total_bytes;
    logic [clea_pkg::BYTES_W-1:0]  o_payload_bytes;
    logic [clea_pkg::UNITS_W-1:0]  o_length_units;
    logic                          o_wrapped_flag;
    logic                          o_empty_flag;
    logic                          o_full_flag;
    logic [clea_pkg::FREE_W-1:0]   o_free_bytes;

    circular_log_entry_allocator_unit #(
        .HEADER_BYTES (HEADER_BYTES),
        .ALLOC_UNIT   (ALLOC_UNIT),
        .LOG_START    (LOG_START),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_payload_size    (i_payload_size),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_entry_address   (o_entry_address),
        .o_payload_address (o_payload_address),
        .o_total_bytes     (o_total_bytes),
        .o_payload_bytes   (o_payload_bytes),
        .o_length_units    (o_length_units),
        .o_wrapped_flag    (o_wrapped_flag),
        .o_empty_flag      (o_empty_flag),
        .o_full_flag       (o_full_flag),
        .o_free_bytes      (o_free_bytes)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the allocator: register copies and pointer state.
    // Registers start at their reset values; the pointer at the log start.
    // ------------------------------------------------------------------
    longint unsigned cfg_buffer_end   = 64'd65536;
    longint unsigned cfg_entry_stride = 64'd0;
    logic            cfg_circular     = 1'b0;
    longint unsigned log_next_free    = LOG_START;
    logic            log_wrapped      = 1'b0;

    t_log_request  pending_requests[$];   // words waiting for the driver
    t_alloc_result expected_results[$];   // predictions waiting for the monitor

    int send_idle_pct  = 0;   // chance in 100 that the sender skips a cycle
    int stall_pct      = 0;   // chance in 100 that the receiver stalls
    int long_hold_left = 0;   // armed from the sequencer, counted down by the receiver
    int error_count    = 0;
    int result_count   = 0;
    int quiet_cycles   = 0;

    // Pointer bump, clamped so it never leaves its 33-bit range
    function automatic longint unsigned bumped_pointer(longint unsigned base,
                                                       longint unsigned amount);
        longint unsigned sum;
        sum = base + amount;
        return (sum > PTR_MAX) ? PTR_MAX : sum;
    endfunction

    // Work out the result of one request and advance the shadow state.
    function automatic t_alloc_result alloc_predict(logic [clea_pkg::CMD_W-1:0] cmd,
                                                    logic [clea_pkg::PSIZE_W-1:0] psize);
        t_alloc_result   r;
        longint unsigned asked;
        longint unsigned req;
        longint unsigned start;
        logic            fits;
        r = '{default: '0};
        if (cmd == clea_pkg::CMD_SIZED || cmd == clea_pkg::CMD_STRIDE) begin
            asked = (cmd == clea_pkg::CMD_SIZED) ? longint'(psize) + HEADER_BYTES
                                                 : cfg_entry_stride;
            req   = ((asked + ALLOC_UNIT - 1) / ALLOC_UNIT) * ALLOC_UNIT;
            start = log_next_free;
            // The pointer moves even when the entry does not fit
            log_next_free = bumped_pointer(start, req);
            fits = (start + req) <= cfg_buffer_end;
            // Circular mode: one retry from the log start, never more
            if (!fits && cfg_circular) begin
                log_wrapped   = 1'b1;
                start         = LOG_START;
                log_next_free = bumped_pointer(start, req);
                fits          = (start + req) <= cfg_buffer_end;
            end
            if (fits) begin
                r.status          = clea_pkg::ST_GRANTED;
                r.entry_address   = ADDR_WIDTH'(start);
                r.payload_address = ADDR_WIDTH'(start + HEADER_BYTES);
                r.total_bytes     = clea_pkg::BYTES_W'(req);
                r.payload_bytes   = (req > HEADER_BYTES)
                                  ? clea_pkg::BYTES_W'(req - HEADER_BYTES) : '0;
                r.length_units    = clea_pkg::UNITS_W'(req / ALLOC_UNIT);
            end else begin
                r.status = clea_pkg::ST_REFUSED;
            end
        end else if (cmd == clea_pkg::CMD_RESET ||
                     log_next_free + clea_pkg::NEAR_FULL_BYTES >= cfg_buffer_end) begin
            log_next_free = LOG_START;
            log_wrapped   = 1'b0;
            r.status      = clea_pkg::ST_RST_DONE;
        end else begin
            r.status = clea_pkg::ST_RST_SKIP;
        end
        // Flags reflect the state after the step
        r.wrapped    = log_wrapped;
        r.empty      = (log_next_free == LOG_START);
        r.full       = (log_next_free >= cfg_buffer_end);
        r.free_bytes = (log_next_free < cfg_buffer_end)
                     ? clea_pkg::FREE_W'(cfg_buffer_end - log_next_free) : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: a taken word is predicted at the edge that takes it, then
    // the next pending word (if any, and if not idling) goes on the bus.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_log_request req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_results.push_back(alloc_predict(i_command, i_payload_size));
            if (!i_valid || !o_stall) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    i_valid        <= 1'b1;
                    i_command      <= req.cmd;
                    i_payload_size <= req.psize;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         result_count, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: compare each taken result word with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("result %0d arrived with nothing outstanding", result_count);
            end else begin
                want = expected_results.pop_front();
                check_field("status",          want.status,          o_status);
                check_field("entry_address",   want.entry_address,   o_entry_address);
                check_field("payload_address", want.payload_address, o_payload_address);
                check_field("total_bytes",     want.total_bytes,     o_total_bytes);
                check_field("payload_bytes",   want.payload_bytes,   o_payload_bytes);
                check_field("length_units",    want.length_units,    o_length_units);
                check_field("wrapped_flag",    want.wrapped,         o_wrapped_flag);
                check_field("empty_flag",      want.empty,           o_empty_flag);
                check_field("full_flag",       want.full,            o_full_flag);
                check_field("free_bytes",      want.free_bytes,      o_free_bytes);
            end
            result_count++;
        end
    end

    // Receiver: a long hold-off is counted down first, else a random stall
    always @(posedge i_clk) begin
        if (long_hold_left > 0) begin
            i_stall <= 1'b1;
            long_hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: any word moving on either side restarts the count
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** circular_log_entry_allocator_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [clea_pkg::CMD_W-1:0] cmd,
                                 input logic [clea_pkg::PSIZE_W-1:0] psize);
        t_log_request r;
        r.cmd   = cmd;
        r.psize = psize;
        pending_requests.push_back(r);
    endtask

    // Block until every queued word has been taken and answered
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_requests.size() != 0 || expected_results.size() != 0 || i_valid);
    endtask

    task automatic write_reg(input logic [clea_pkg::CFG_IDX_W-1:0] idx,
                             input logic [clea_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            clea_pkg::CFG_BUFFER_END:   cfg_buffer_end   = value;
            clea_pkg::CFG_ENTRY_STRIDE: cfg_entry_stride = value[clea_pkg::STRIDE_W-1:0];
            clea_pkg::CFG_CIRC_MODE:    cfg_circular     = value[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Only called with the block idle
    task automatic configure(input logic [clea_pkg::CFG_W-1:0] buf_end,
                             input logic [clea_pkg::CFG_W-1:0] stride,
                             input logic circular);
        write_reg(clea_pkg::CFG_BUFFER_END, buf_end);
        write_reg(clea_pkg::CFG_ENTRY_STRIDE, stride);
        write_reg(clea_pkg::CFG_CIRC_MODE, {{(clea_pkg::CFG_W-1){1'b0}}, circular});
        @(negedge i_clk);
    endtask

    initial begin
        int                           p;
        int                           n;
        int                           pick;
        logic [clea_pkg::CMD_W-1:0]   cmd;
        logic [clea_pkg::PSIZE_W-1:0] psize;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed: reset defaults (end 64K, stride 0, linear) ---
        queue_request(clea_pkg::CMD_STRIDE, 16'd0);       // zero stride, granted with empty entry
        queue_request(clea_pkg::CMD_SIZED, 16'd0);        // header only
        queue_request(clea_pkg::CMD_SIZED, 16'd1);        // rounds up to next unit
        queue_request(clea_pkg::CMD_SIZED, 16'hFFFF);     // too big: refused, pointer past end
        queue_request(clea_pkg::CMD_RESET_NF, 16'h0);     // past end, so the reset is taken
        queue_request(clea_pkg::CMD_SIZED, 16'h5555);
        queue_request(clea_pkg::CMD_SIZED, 16'hAAAA);     // refused in linear mode
        queue_request(clea_pkg::CMD_RESET, 16'hFFFF);
        queue_request(clea_pkg::CMD_RESET_NF, 16'hFFFF);  // plenty of room: skipped
        wait_drained();

        // header larger than the entry
        configure(32'd65536, 32'd16, 1'b0);
        queue_request(clea_pkg::CMD_STRIDE, 16'h1234);
        wait_drained();
        configure(32'd65536, 32'd1, 1'b0);
        queue_request(clea_pkg::CMD_STRIDE, 16'd0);
        wait_drained();

        // circular mode on a 512-byte buffer: wrap, then a retry that fails
        configure(32'd512, 32'd65535, 1'b1);
        queue_request(clea_pkg::CMD_SIZED, 16'd200);
        queue_request(clea_pkg::CMD_SIZED, 16'd0);        // wraps and fits
        queue_request(clea_pkg::CMD_SIZED, 16'hFFFF);     // wraps and still refused
        queue_request(clea_pkg::CMD_STRIDE, 16'd0);
        queue_request(clea_pkg::CMD_RESET, 16'd0);        // clears wrapped
        wait_drained();

        // buffer end below the log start
        configure(32'd200, 32'd0, 1'b1);
        queue_request(clea_pkg::CMD_STRIDE, 16'd0);
        queue_request(clea_pkg::CMD_SIZED, 16'd0);
        queue_request(clea_pkg::CMD_RESET_NF, 16'd0);
        wait_drained();

        // Linear refusals on a tiny buffer keep pushing the pointer past the end
        configure(32'd512, 32'd0, 1'b0);
        for (n = 0; n < 20; n++)
            queue_request(clea_pkg::CMD_SIZED, 16'hFFFF);
        queue_request(clea_pkg::CMD_STRIDE, 16'd0);
        queue_request(clea_pkg::CMD_RESET_NF, 16'd0);
        wait_drained();

        // --- random phases: sender and receiver pacing cycles through four settings ---
        for (p = 0; p < 8; p++) begin
            case (p)
                0: configure(32'd2048, 32'd48, 1'b1);
                1: configure(32'd4096, 32'd65535, 1'b0);
                2: configure(32'd512, 32'd1, 1'b1);
                3: configure(32'hFFFF_FFFF, 32'd100, 1'b0);
                4: configure(32'd1000, 32'd0, 1'b1);
                5: configure(32'd65536, 32'd300, 1'b1);
                6: configure(32'd3000, 32'd16, 1'b0);
                default: configure(32'h8000_0000, 32'd65535, 1'b1);
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            // Receiver holds off while the sender keeps pushing: block fills up
            if (p == 0 || p == 4)
                long_hold_left = 60;
            for (n = 0; n < 100; n++) begin
                pick = $urandom_range(99);
                if (pick < 45)      cmd = clea_pkg::CMD_SIZED;
                else if (pick < 80) cmd = clea_pkg::CMD_STRIDE;
                else if (pick < 90) cmd = clea_pkg::CMD_RESET_NF;
                else                cmd = clea_pkg::CMD_RESET;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: psize = clea_pkg::PSIZE_W'($urandom_range(200));
                    5, 6:          psize = clea_pkg::PSIZE_W'($urandom_range(2047));
                    7, 8:          psize = clea_pkg::PSIZE_W'($urandom());
                    default:       psize = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                endcase
                queue_request(cmd, psize);
                // Sender pauses mid phase until every result is back
                if (n == 49)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (error_count == 0)
            $display("** circular_log_entry_allocator_unit: PASSED **");
        else
            $display("** circular_log_entry_allocator_unit: FAILED **");
        $finish;
    end

endmodule
